/* src/sem_pkg.sv */
// Shared types and constants for the Sobel edge magnitude block.
// Used by sem_front, sem_queue, sem_back and sobel_edge_magnitude; no dependencies.
package sem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   localparam int PIXEL_W    = 8;
   localparam int POS_W      = 10;
   localparam int MAG_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int GRAD_W     = 11;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [MAG_W-1:0] MAG_SAT = 8'd255;

   // One classified pixel on its way from the front end to the datapath.
   typedef struct packed {
      logic [PIXEL_W-1:0] px;
      logic [COL_W-1:0]   col;
      logic               emit;
      logic               zero;
      logic               last;
      logic [ROW_W-1:0]   out_row;
      logic [COL_W-1:0]   out_col;
   } item_type;

endpackage

/* src/sem_front.sv */
// Front end: frame geometry registers, raster counters and pixel classification.
// Depends on sem_pkg.
module sem_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sem_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sem_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               queue_full,
   output logic                               push,
   output sem_pkg::item_type                  push_item
);

   logic [sem_pkg::COL_W-1:0] wm1_ff, wm1_in;
   logic [sem_pkg::ROW_W-1:0] hm1_ff, hm1_in;
   logic [sem_pkg::COL_W-1:0] col_ff, col_in;
   logic [sem_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      csr_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // Store dimension minus one, clamped into 1..MAX.
   always_comb begin
      wm1_in = wm1_ff;
      hm1_in = hm1_ff;
      if (csr_write && csr_index == sem_pkg::CSR_FRAME_WIDTH) begin
         priority if (csr_data == '0) begin
            wm1_in = '0;
         end else if (32'(csr_data) > sem_pkg::MAX_WIDTH) begin
            wm1_in = sem_pkg::COL_W'(sem_pkg::MAX_WIDTH - 1);
         end else begin
            wm1_in = sem_pkg::COL_W'(32'(csr_data) - 32'd1);
         end
      end
      if (csr_write && csr_index == sem_pkg::CSR_FRAME_HEIGHT) begin
         priority if (csr_data == '0) begin
            hm1_in = '0;
         end else if (32'(csr_data) > sem_pkg::MAX_HEIGHT) begin
            hm1_in = sem_pkg::ROW_W'(sem_pkg::MAX_HEIGHT - 1);
         end else begin
            hm1_in = sem_pkg::ROW_W'(32'(csr_data) - 32'd1);
         end
      end
   end

   // Advance the raster position; wrap also covers a counter left past a new width.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (col_ff >= wm1_ff) begin
            col_in = '0;
            row_in = (row_ff >= hm1_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      push_item.px      = req_tdata[sem_pkg::PIXEL_W-1:0];
      push_item.col     = col_ff;
      push_item.emit    = (row_ff != '0) && (col_ff != '0);
      push_item.zero    = !((row_ff >= sem_pkg::ROW_W'(2)) && (col_ff >= sem_pkg::COL_W'(2)));
      push_item.last    = (row_ff == hm1_ff) && (col_ff == wm1_ff);
      push_item.out_row = row_ff - 1'b1;
      push_item.out_col = col_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff <= sem_pkg::COL_W'(sem_pkg::MAX_WIDTH - 1);
         hm1_ff <= sem_pkg::ROW_W'(sem_pkg::MAX_HEIGHT - 1);
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         wm1_ff <= wm1_in;
         hm1_ff <= hm1_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

/* src/sem_queue.sv */
// Short FIFO of classified pixels between front end and datapath.
// Depends on sem_pkg.
module sem_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sem_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output sem_pkg::item_type  head
);

   sem_pkg::item_type              entry_ff [sem_pkg::QUEUE_DEPTH];
   logic [sem_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sem_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sem_pkg::QPTR_W:0]       count_ff, count_in;

   assign full      = (count_ff == (sem_pkg::QPTR_W+1)'(sem_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a transfer");

endmodule

/* src/sem_back.sv */
// Datapath: line buffers, 3x3 window, Sobel gradients, magnitude and output register.
// Depends on sem_pkg.
module sem_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              not_empty,
   input  sem_pkg::item_type                 head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sem_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);

   logic [sem_pkg::PIXEL_W-1:0] line_prev  [sem_pkg::MAX_WIDTH];
   logic [sem_pkg::PIXEL_W-1:0] line_prev2 [sem_pkg::MAX_WIDTH];

   // stage B: line buffer data and window
   logic                        b_valid_ff, b_valid_in;
   sem_pkg::item_type           b_item_ff;
   logic [sem_pkg::PIXEL_W-1:0] top_raw_ff, mid_raw_ff;
   logic                        fwd_ff;
   logic [sem_pkg::PIXEL_W-1:0] fwd_top_ff, fwd_mid_ff;
   logic [sem_pkg::PIXEL_W-1:0] win_ff [6];
   logic [sem_pkg::PIXEL_W-1:0] top, mid;
   logic                        adv_b, b_free, fwd_in;
   logic [9:0]                  gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [sem_pkg::GRAD_W-1:0] gx, gy;

   // stage C: gradients
   logic                        c_valid_ff, c_valid_in;
   logic signed [sem_pkg::GRAD_W-1:0] c_gx_ff, c_gy_ff;
   logic [sem_pkg::ROW_W-1:0]   c_row_ff;
   logic [sem_pkg::COL_W-1:0]   c_col_ff;
   logic                        c_last_ff, c_zero_ff;
   logic                        c_free, load_r;
   logic [9:0]                  abs_gx, abs_gy;
   logic [10:0]                 sum;
   logic [sem_pkg::MAG_W-1:0]   mag;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sem_pkg::POS_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic [sem_pkg::MAG_W-1:0]   rsp_mag_ff;
   logic                        rsp_last_ff;

   assign load_r = c_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign c_free = !c_valid_ff || load_r;
   assign adv_b  = b_valid_ff && c_free;
   assign b_free = !b_valid_ff || adv_b;
   assign pop    = not_empty && b_free;

   // Same column read while the older pixel writes it (width of one): bypass.
   assign fwd_in = adv_b && (head.col == b_item_ff.col);
   assign top    = fwd_ff ? fwd_top_ff : top_raw_ff;
   assign mid    = fwd_ff ? fwd_mid_ff : mid_raw_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         top_raw_ff <= line_prev2[head.col];
         mid_raw_ff <= line_prev[head.col];
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         line_prev2[b_item_ff.col] <= mid;
         line_prev[b_item_ff.col]  <= b_item_ff.px;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_item_ff  <= head;
         fwd_top_ff <= mid;
         fwd_mid_ff <= b_item_ff.px;
      end
   end

   // window: [0..2] column c-2 top/mid/bottom, [3..5] column c-1
   always_comb begin
      gx_pos = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, b_item_ff.px};
      gx_neg = {2'b00, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b00, win_ff[2]};
      gy_pos = {2'b00, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b00, b_item_ff.px};
      gy_neg = {2'b00, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b00, top};
      gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop) begin
         b_valid_in = 1'b1;
      end else if (adv_b) begin
         b_valid_in = 1'b0;
      end
      c_valid_in = c_valid_ff;
      if (adv_b && b_item_ff.emit) begin
         c_valid_in = 1'b1;
      end else if (load_r) begin
         c_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_r) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            fwd_ff <= fwd_in;
         end
         if (adv_b) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top;
            win_ff[4] <= mid;
            win_ff[5] <= b_item_ff.px;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_b && b_item_ff.emit) begin
         c_gx_ff   <= gx;
         c_gy_ff   <= gy;
         c_row_ff  <= b_item_ff.out_row;
         c_col_ff  <= b_item_ff.out_col;
         c_last_ff <= b_item_ff.last;
         c_zero_ff <= b_item_ff.zero;
      end
   end

   always_comb begin
      abs_gx = c_gx_ff[sem_pkg::GRAD_W-1] ? 10'(-c_gx_ff) : 10'(c_gx_ff);
      abs_gy = c_gy_ff[sem_pkg::GRAD_W-1] ? 10'(-c_gy_ff) : 10'(c_gy_ff);
      sum    = {1'b0, abs_gx} + {1'b0, abs_gy};
      priority if (c_zero_ff) begin
         mag = '0;
      end else if (sum > 11'(sem_pkg::MAG_SAT)) begin
         mag = sem_pkg::MAG_SAT;
      end else begin
         mag = sum[sem_pkg::MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_r) begin
         rsp_row_ff  <= sem_pkg::POS_W'(c_row_ff);
         rsp_col_ff  <= sem_pkg::POS_W'(c_col_ff);
         rsp_mag_ff  <= mag;
         rsp_last_ff <= c_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_mag_ff, rsp_col_ff, rsp_row_ff};

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      load_r && c_zero_ff |=> rsp_mag_ff == '0)
      else $error("border centre produced a nonzero magnitude");
   a_b_holds: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !adv_b |=> b_valid_ff && $stable(b_item_ff))
      else $error("stalled window stage lost its pixel");
   a_emit_reaches_c: assert property (@(posedge clock) disable iff (reset)
      adv_b && b_item_ff.emit |=> c_valid_ff)
      else $error("emitted centre dropped before gradient stage");

endmodule

/* src/sobel_edge_magnitude.sv */
// Top level of the Sobel 3x3 edge magnitude stream filter.
// Depends on sem_pkg, sem_front, sem_queue and sem_back.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata[7:0] pixel
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata row/col/magnitude, rsp_tlast frame_last
//  csr      in   csr_valid/csr_ready    csr_index, csr_data[10:0]
//
// One pixel per clock sustained while rsp_tready stays high. A transferred pixel passes
// the queue, the window stage (pop with line buffer read), gradient and output registers.
// The line buffer read port sets the pace: one read and one write per memory per cycle.
// Reset is synchronous and clears counters, window and valid bits; line buffers are not cleared.
// A stalled rsp side backs up through the four-entry queue before req_tready drops.
module sobel_edge_magnitude (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sem_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] pixel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sem_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [9:0] out_row, [19:10] out_col,
                                                         // [27:20] magnitude, [31:28] zero
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sem_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic              queue_full;
   logic              push;
   sem_pkg::item_type push_item;
   logic              pop;
   logic              not_empty;
   sem_pkg::item_type head;

   sem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   sem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   sem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
